FILE: rtl/sakv_pkg.sv
// sakv_pkg: shared command codes and cell control types for the sorted key/value store
// no dependencies; imported by sakv_cell and sorted_array_key_value_store_core

package sakv_pkg;

    // command codes on the mode field
    localparam logic [1:0] MODE_GET = 2'd0;
    localparam logic [1:0] MODE_PUT = 2'd1;
    localparam logic [1:0] MODE_DEL = 2'd2;

    // what every cell does on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_UPDATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     signed_keys;
    } cell_ctrl_t;

endpackage

FILE: rtl/sakv_cell.sv
// sakv_cell: one slot of the sorted chain, holds a key/value pair and trades it with its neighbors
// depends on sakv_pkg

module sakv_cell #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int SLOT_W      = 7,
    parameter int INDEX       = 0
) (
    input  logic                    clk,
    input  sakv_pkg::cell_ctrl_t    ctrl,
    input  logic [SLOT_W-1:0]       slot,
    input  logic [KEY_WIDTH-1:0]    new_key,
    input  logic [VALUE_WIDTH-1:0]  new_value,
    input  logic [KEY_WIDTH-1:0]    lower_key,
    input  logic [VALUE_WIDTH-1:0]  lower_value,
    input  logic [KEY_WIDTH-1:0]    upper_key,
    input  logic [VALUE_WIDTH-1:0]  upper_value,
    output logic [KEY_WIDTH-1:0]    cell_key,
    output logic [VALUE_WIDTH-1:0]  cell_value,
    output logic                    key_lt,
    output logic                    key_eq
);
    import sakv_pkg::*;

    localparam logic [SLOT_W-1:0]    MY_INDEX = SLOT_W'(INDEX);
    localparam logic [KEY_WIDTH-1:0] KEY_MSB  = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   key_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [KEY_WIDTH-1:0]   flip;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_INDEX == slot)
                begin
                    key_next   = new_key;
                    value_next = new_value;
                end
                else if (MY_INDEX > slot)
                begin
                    key_next   = lower_key;
                    value_next = lower_value;
                end
            end
            CELL_DELETE:
            begin
                if (MY_INDEX >= slot)
                begin
                    key_next   = upper_key;
                    value_next = upper_value;
                end
            end
            CELL_UPDATE:
            begin
                if (MY_INDEX == slot)
                    value_next = new_value;
            end
            default:
            begin
                key_next   = key_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    // signed order is unsigned order with the sign bit flipped
    assign flip       = ctrl.signed_keys ? KEY_MSB : '0;
    assign key_lt     = (key_reg ^ flip) < (new_key ^ flip);
    assign key_eq     = key_reg == new_key;
    assign cell_key   = key_reg;
    assign cell_value = value_reg;

endmodule

FILE: rtl/sorted_array_key_value_store_core.sv
// sorted_array_key_value_store_core: top level of the sorted key/value store
// depends on sakv_pkg and sakv_cell

// Sorted key/value store built as a chain of CAPACITY cells, each holding one pair in
// ascending key order (signed or unsigned compare, chosen by cfg_wdata written with cfg_we,
// reset to signed). A command word (get, put, delete) is taken only while the block is idle.
// Every cell compares its key with the command key in the compare state; a binary search then walks
// the registered less-than flags one halving per cycle; the last cycle inserts, deletes or
// updates, the whole chain shifting by one cell at once. The search needs at most
// ceil(log2(count+1)) halvings, none on an empty store. The result word sits in an output
// register, so the next command is accepted while it waits on out_ready; a command whose
// result cannot be written yet waits in its final cycle.

module sorted_array_key_value_store_core #(
    parameter int CAPACITY    = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [31:0] read_value,
    output logic        refused_full,
    output logic [6:0]  entry_count
);
    import sakv_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_COMPARE = 4'b0010,
        S_SEARCH  = 4'b0100,
        S_EXEC    = 4'b1000
    } state_t;

    // control registers
    state_t           state_reg, state_next;
    logic             signed_keys_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic             out_valid_reg, out_valid_next;

    // command and result payload
    logic [1:0]             mode_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [CAPACITY-1:0]    lt_vec_reg;
    logic [CAPACITY-1:0]    eq_vec_reg;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic                   found_reg, found_next;
    logic [31:0]            read_value_reg, read_value_next;
    logic                   refused_reg, refused_next;
    logic [6:0]             out_count_reg;

    // chain wiring
    logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]    cell_lt;
    logic [CAPACITY-1:0]    cell_eq;
    cell_ctrl_t             cell_ctrl;

    // resizing of the fixed-width ports to the stored widths
    logic [KEY_WIDTH+31:0]   key_wide;
    logic [VALUE_WIDTH+31:0] value_wide;
    logic [VALUE_WIDTH+31:0] rd_wide;
    logic [CNT_W+6:0]        count_wide;

    logic [CNT_W-1:0] mid;
    logic [IDX_W-1:0] mid_idx;
    logic [IDX_W-1:0] lo_idx;
    logic             in_fire;
    logic             exec_fire;
    logic             hit;
    logic             full;

    assign key_wide   = {{KEY_WIDTH{1'b0}}, key};
    assign value_wide = {{VALUE_WIDTH{1'b0}}, value};
    assign rd_wide    = {{32{rd_val_reg[VALUE_WIDTH-1]}}, rd_val_reg};
    assign count_wide = {7'd0, count_next};

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // one halving of the search window per cycle over the less-than flags
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_idx = mid[IDX_W-1:0];
    assign lo_idx  = lo_reg[IDX_W-1:0];

    // lo is the first slot not below the key; a hit needs it inside the count
    assign hit  = (lo_reg < count_reg) && eq_vec_reg[lo_idx];
    assign full = (count_reg == FULL_COUNT);

    // cell chain, each cell sees the pair below (insert) and above (delete)
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0]   lower_key;
        logic [VALUE_WIDTH-1:0] lower_value;
        logic [KEY_WIDTH-1:0]   upper_key;
        logic [VALUE_WIDTH-1:0] upper_value;

        if (i == 0)
        begin : g_bottom
            assign lower_key   = '0;
            assign lower_value = '0;
        end
        else
        begin : g_lower
            assign lower_key   = cell_key[i-1];
            assign lower_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign upper_key   = '0;
            assign upper_value = '0;
        end
        else
        begin : g_upper
            assign upper_key   = cell_key[i+1];
            assign upper_value = cell_value[i+1];
        end

        sakv_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .SLOT_W      (CNT_W),
            .INDEX       (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .slot        (lo_reg),
            .new_key     (key_reg),
            .new_value   (value_reg),
            .lower_key   (lower_key),
            .lower_value (lower_value),
            .upper_key   (upper_key),
            .upper_value (upper_value),
            .cell_key    (cell_key[i]),
            .cell_value  (cell_value[i]),
            .key_lt      (cell_lt[i]),
            .key_eq      (cell_eq[i])
        );
    end

    // sequencer: accept, compare all cells, search, execute
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (lo_reg == hi_reg)
                    state_next = S_EXEC;
                else if (lt_vec_reg[mid_idx])
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
            end
            S_EXEC:
            begin
                if (exec_fire)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command decode in the final cycle
    always_comb
    begin
        cell_ctrl.op          = CELL_HOLD;
        cell_ctrl.signed_keys = signed_keys_reg;
        count_next            = count_reg;
        found_next            = 1'b0;
        read_value_next       = '0;
        refused_next          = 1'b0;
        case (mode_reg)
            MODE_GET:
            begin
                found_next = hit;
                if (hit)
                    read_value_next = rd_wide[31:0];
            end
            MODE_PUT:
            begin
                found_next = hit;
                if (hit)
                    cell_ctrl.op = CELL_UPDATE;
                else if (full)
                    refused_next = 1'b1;
                else
                begin
                    cell_ctrl.op = CELL_INSERT;
                    count_next   = count_reg + 1'b1;
                end
            end
            MODE_DEL:
            begin
                found_next = hit;
                if (hit)
                begin
                    cell_ctrl.op = CELL_DELETE;
                    count_next   = count_reg - 1'b1;
                end
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
        // nothing moves until the result register can take the word
        if (!exec_fire)
        begin
            cell_ctrl.op = CELL_HOLD;
            count_next   = count_reg;
        end
    end

    always_comb
    begin
        if (exec_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            signed_keys_reg <= 1'b1;
            count_reg       <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                signed_keys_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= mode;
            key_reg   <= key_wide[KEY_WIDTH-1:0];
            value_reg <= value_wide[VALUE_WIDTH-1:0];
        end
        if (state_reg == S_COMPARE)
        begin
            lt_vec_reg <= cell_lt;
            eq_vec_reg <= cell_eq;
        end
        // registered read of the pair the search settles on
        if ((state_reg == S_SEARCH) && (lo_reg == hi_reg))
            rd_val_reg <= cell_value[lo_idx];
        if (exec_fire)
        begin
            found_reg      <= found_next;
            read_value_reg <= read_value_next;
            refused_reg    <= refused_next;
            out_count_reg  <= count_wide[6:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign read_value   = read_value_reg;
    assign refused_full = refused_reg;
    assign entry_count  = out_count_reg;

    // the store never holds more pairs than it has cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("pair count above capacity");

    // the pair count only moves on the cycle a command executes
    a_count_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(exec_fire))
        else $error("pair count changed outside execute");

    // a refused put is only ever reported against a full store
    a_refused_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && refused_next) |-> full)
        else $error("put refused while store not full");

    // a new result word comes only from the execute cycle
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised outside execute");

endmodule

FILE: tb/kv_scoreboard_pkg.sv
// kv_scoreboard_pkg: result word type and scoreboard class for the sorted key/value store bench
// depends on sakv_pkg for the command codes

package kv_scoreboard_pkg;

    import sakv_pkg::*;

    localparam int         STORE_DEPTH = 64;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        refused_full;
        logic [6:0]  entry_count;
    } kv_result_t;

    class kv_scoreboard;

        logic [31:0] pair_key [STORE_DEPTH];
        logic [31:0] pair_val [STORE_DEPTH];
        int unsigned pair_total;
        bit          signed_order;
        kv_result_t  expected_q[$];
        int          errors;

        function new();
            pair_total   = 0;
            signed_order = 1'b1;
            errors       = 0;
        endfunction

        function void set_order(bit signed_keys);
            signed_order = signed_keys;
        endfunction

        // unsigned rank that follows the selected key ordering
        function logic [31:0] rank(logic [31:0] k);
            return signed_order ? (k ^ 32'h8000_0000) : k;
        endfunction

        // first slot whose key does not rank below k
        function int unsigned lower_slot(logic [31:0] k);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = pair_total;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (rank(pair_key[mid]) < rank(k))
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function void note_command(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
            kv_result_t  e;
            int unsigned slot;
            bit          hit;
            e    = '0;
            slot = lower_slot(key);
            hit  = (slot < pair_total) && (pair_key[slot] == key);
            case (mode)
                MODE_GET:
                begin
                    if (hit)
                    begin
                        e.found      = 1'b1;
                        e.read_value = pair_val[slot];
                    end
                end
                MODE_PUT:
                begin
                    if (hit)
                    begin
                        e.found        = 1'b1;
                        pair_val[slot] = value;
                    end
                    else if (pair_total >= STORE_DEPTH)
                        e.refused_full = 1'b1;
                    else
                    begin
                        for (int unsigned i = pair_total; i > slot; i--)
                        begin
                            pair_key[i] = pair_key[i - 1];
                            pair_val[i] = pair_val[i - 1];
                        end
                        pair_key[slot] = key;
                        pair_val[slot] = value;
                        pair_total++;
                    end
                end
                MODE_DEL:
                begin
                    if (hit)
                    begin
                        e.found = 1'b1;
                        for (int unsigned i = slot; i + 1 < pair_total; i++)
                        begin
                            pair_key[i] = pair_key[i + 1];
                            pair_val[i] = pair_val[i + 1];
                        end
                        pair_total--;
                    end
                end
                default:
                begin
                end
            endcase
            e.entry_count = pair_total[6:0];
            expected_q.push_back(e);
        endfunction

        function void check_result(kv_result_t got);
            kv_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result word with no command pending");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.found !== e.found)
            begin
                $error("found: expected %0d, actual %0d", e.found, got.found);
                errors++;
            end
            if (got.read_value !== e.read_value)
            begin
                $error("read_value: expected %h, actual %h", e.read_value, got.read_value);
                errors++;
            end
            if (got.refused_full !== e.refused_full)
            begin
                $error("refused_full: expected %0d, actual %0d", e.refused_full,
                       got.refused_full);
                errors++;
            end
            if (got.entry_count !== e.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d", e.entry_count,
                       got.entry_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] pick_stored_key();
            if (pair_total == 0)
                return $urandom();
            return pair_key[$urandom_range(pair_total - 1)];
        endfunction

    endclass

endpackage

FILE: tb/sorted_array_key_value_store_core_test.sv
// sorted_array_key_value_store_core_test: bench for the sorted key/value store core
// depends on sakv_pkg, kv_scoreboard_pkg and the core with its cells

module sorted_array_key_value_store_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sakv_pkg::*;
    import kv_scoreboard_pkg::*;

    localparam int POOL_SIZE   = 80;
    localparam int PHASE_ITEMS = 345;
    localparam int TAIL_CYCLES = 32;
    localparam int LONG_HOLD   = 400;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic        cfg_wdata    = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [1:0]  mode         = MODE_GET;
    logic [31:0] key          = '0;
    logic [31:0] value        = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        found;
    logic [31:0] read_value;
    logic        refused_full;
    logic [6:0]  entry_count;

    kv_scoreboard sb = new();

    // idling knobs, percent of cycles
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    // set by the sender, turned into a counted hold-off by the receiver
    bit          long_hold_req  = 1'b0;
    logic [31:0] key_pool [POOL_SIZE];

    sorted_array_key_value_store_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .key          (key),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .read_value   (read_value),
        .refused_full (refused_full),
        .entry_count  (entry_count)
    );

    always #10 clk = ~clk;

    // offer one command word, with random idle cycles first, and hold it until taken
    task automatic send_command(logic [1:0] m, logic [31:0] k, logic [31:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        // predict at the accepting edge, in acceptance order
        sb.note_command(m, k, v);
    endtask

    // sender waits until every expected result word has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // register writes only on an idle block
    task automatic write_ordering(logic signed_keys);
        wait_drained();
        // let any command still in the search chain settle
        repeat (TAIL_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= signed_keys;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_order(signed_keys);
    endtask

    // mostly keys that recur, so hits, fills and refusals all happen
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        else if (r < 85)
            return sb.pick_stored_key();
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(39))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // put-heavy while filling, delete-heavy while draining
    function automatic logic [1:0] pick_mode(bit filling);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return MODE_NOP;
        if (filling)
            return (r < 60) ? MODE_PUT : (r < 85) ? MODE_GET : MODE_DEL;
        return (r < 24) ? MODE_PUT : (r < 54) ? MODE_GET : MODE_DEL;
    endfunction

    // receiver: ready decided at the falling edge, word taken at the rising edge
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result('{found, read_value, refused_full, entry_count});
        end
    end

    // stimulus
    initial
    begin
        int send_phase [4];
        int recv_phase [4];
        send_phase = '{0, 77, 0, 15};
        recv_phase = '{0, 0, 77, 15};

        // recurring keys: ordering extremes first, then random bits
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        key_pool[5] = 32'h8000_0001;
        for (int i = 6; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, ordering at its reset value of signed
        send_command(MODE_GET, 32'h0000_0000, 32'h0);          // lookup on empty store
        send_command(MODE_DEL, 32'h0000_0005, 32'h0);          // delete absent on empty
        send_command(MODE_NOP, 32'h0000_0000, 32'h1234_5678);  // unused mode
        send_command(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_command(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_command(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_command(MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_command(MODE_GET, 32'h8000_0000, 32'h0);
        send_command(MODE_GET, 32'h7FFF_FFFF, 32'h0);
        send_command(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(MODE_GET, 32'h1234_5678, 32'h0);          // absent key
        send_command(MODE_PUT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);  // overwrite present key
        send_command(MODE_GET, 32'h7FFF_FFFF, 32'h0);
        send_command(MODE_DEL, 32'h0000_0000, 32'h0);
        send_command(MODE_DEL, 32'h0000_0000, 32'h0);          // already gone
        send_command(MODE_GET, 32'h0000_0000, 32'h0);
        send_command(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(MODE_DEL, 32'h8000_0000, 32'h0);          // lowest entry
        send_command(MODE_DEL, 32'h7FFF_FFFF, 32'h0);          // highest entry
        send_command(MODE_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_command(MODE_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_command(MODE_GET, 32'hAAAA_AAAA, 32'h0);

        // flip ordering with pairs still stored, no re-sort
        write_ordering(1'b0);
        send_command(MODE_GET, 32'hFFFF_FFFF, 32'h0);
        send_command(MODE_PUT, 32'h0000_0001, 32'h0000_0001);
        send_command(MODE_GET, 32'h5555_5555, 32'h0);

        // random phases, each with its own idling and ordering
        for (int p = 0; p < 4; p++)
        begin
            write_ordering(((p + 1) % 2) != 0);
            send_idle_pct  = send_phase[p];
            recv_stall_pct = recv_phase[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while commands keep coming
                if ((p % 2 == 0) && n == 100)
                    long_hold_req = 1'b1;
                // sender pause until everything is back
                if (n == 250)
                    wait_drained();
                send_command(pick_mode(n < PHASE_ITEMS * 6 / 10), pick_key(), pick_value());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
